### rtl/lhs_pkg.sv
// Shared types, codes and constants of the latency histogram statistics block.
package lhs_pkg;

   localparam int TIME_W = 32;
   localparam int CNT_W = 40;
   localparam int SUM_W = 64;
   localparam int BKT_W = 32;
   localparam int X_W = 47;
   localparam int BKT_US = 1000;
   localparam int RECIP_W = 29;
   localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
   localparam int RECIP_SHIFT = 38;
   localparam int PROD_W = TIME_W + RECIP_W;

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [TIME_W-1:0] latency_us;
      logic ok_flag;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] total_count;
      logic [CNT_W-1:0] success_count;
      logic [CNT_W-1:0] fail_count;
      logic [SUM_W-1:0] time_sum;
      logic [TIME_W-1:0] min_time;
      logic [TIME_W-1:0] max_time;
      logic [TIME_W-1:0] p95_time;
      logic [TIME_W-1:0] p99_time;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC_MUL,
      ST_REC_READ,
      ST_REC_WRITE,
      ST_Q_INIT,
      ST_Q_WALK,
      ST_Q_DONE
   } state_type;

   typedef struct packed {
      logic rec_stats;
      logic clr_stats;
      logic addr_rst;
      logic mul;
      logic rd_rec;
      logic wr_rec;
      logic clr_wr;
      logic q_init;
      logic walk;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic addr_end;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

### rtl/lhs_datapath.sv
// Datapath: statistics registers, histogram memory, bucket walk and result register.
module lhs_datapath #(
   parameter int BUCKETS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lhs_pkg::req_item_type req_item,
   input  lhs_pkg::cmd_type     cmd,
   input  logic                 rsp_stall,
   output lhs_pkg::status_type  status,
   output logic                 rsp_valid,
   output lhs_pkg::rsp_item_type rsp_item
);
   import lhs_pkg::*;

   localparam int IDX_W = $clog2(BUCKETS + 1);
   localparam int ACC_W = BKT_W + IDX_W + 7;
   localparam int CMP_W = (ACC_W > X_W) ? ACC_W : X_W;
   localparam logic [TIME_W-1:0] OVF_LIMIT = TIME_W'(BUCKETS * BKT_US);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   logic [BKT_W-1:0] bkt_mem [BUCKETS+1];

   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] ok_ff, ok_in;
   logic [CNT_W-1:0] bad_ff, bad_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic [TIME_W-1:0] max_ff, max_in;
   logic [SUM_W:0] sum_wide;

   logic [TIME_W-1:0] t_ff;
   logic [PROD_W-1:0] prod_ff;
   logic over_ff;
   logic [IDX_W-1:0] rec_idx;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [BKT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [BKT_W-1:0] wr_data;
   logic rd_en, wr_en, issue;

   logic v1_ff, v2_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff;
   logic [CMP_W-1:0] b100_ff;
   logic [CMP_W-1:0] acc_ff, acc_sum;
   logic [CMP_W-1:0] x95_ff, x99_ff;
   logic got95_ff, got99_ff;
   logic [IDX_W-1:0] i95_ff, i99_ff;

   logic rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // record statistics
   always_comb begin
      total_in = total_ff;
      ok_in = ok_ff;
      bad_in = bad_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(req_item.latency_us);
      if (cmd.clr_stats) begin
         total_in = '0;
         ok_in = '0;
         bad_in = '0;
         sum_in = '0;
         min_in = '0;
         max_in = '0;
      end else if (cmd.rec_stats) begin
         total_in = sat_inc(total_ff);
         if (req_item.ok_flag) begin
            ok_in = sat_inc(ok_ff);
         end else begin
            bad_in = sat_inc(bad_ff);
         end
         sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         if (min_ff == '0 || req_item.latency_us < min_ff) begin
            min_in = req_item.latency_us;
         end
         if (req_item.latency_us > max_ff) begin
            max_in = req_item.latency_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ok_ff <= '0;
         bad_ff <= '0;
         sum_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
      end else begin
         total_ff <= total_in;
         ok_ff <= ok_in;
         bad_ff <= bad_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // bucket index by reciprocal multiply
   always_ff @(posedge clock) begin
      if (cmd.rec_stats) begin
         t_ff <= req_item.latency_us;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(t_ff) * PROD_W'(RECIP);
         over_ff <= (t_ff >= OVF_LIMIT);
      end
   end

   assign rec_idx = over_ff ? LAST_IDX : prod_ff[RECIP_SHIFT +: IDX_W];

   // histogram memory port control
   assign issue = cmd.walk && (addr_ff != LAST_IDX) && !got99_ff;
   assign rd_en = issue || cmd.rd_rec;
   assign rd_addr = cmd.walk ? addr_ff : rec_idx;
   assign wr_en = cmd.clr_wr || cmd.wr_rec;
   assign wr_addr = cmd.clr_wr ? addr_ff : rec_idx;
   assign wr_data = cmd.clr_wr ? '0 : ((rd_data_ff == '1) ? rd_data_ff : rd_data_ff + BKT_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bkt_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bkt_mem[rd_addr];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.addr_rst) begin
         addr_in = '0;
      end else if (cmd.clr_wr || issue) begin
         addr_in = addr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // percentile walk: read, scale by 100, accumulate and compare
   assign acc_sum = acc_ff + b100_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         got95_ff <= 1'b0;
         got99_ff <= 1'b0;
      end else if (cmd.q_init) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         got95_ff <= 1'b0;
         got99_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (v2_ff && !got95_ff && acc_sum > x95_ff) begin
            got95_ff <= 1'b1;
         end
         if (v2_ff && !got99_ff && acc_sum > x99_ff) begin
            got99_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= addr_ff;
      idx2_ff <= idx1_ff;
      b100_ff <= CMP_W'(rd_data_ff) * CMP_W'(100);
      if (cmd.q_init) begin
         acc_ff <= CMP_W'(100);
         x95_ff <= CMP_W'(X_W'(total_ff) * X_W'(95));
         x99_ff <= CMP_W'(X_W'(total_ff) * X_W'(99));
      end else if (v2_ff) begin
         acc_ff <= acc_sum;
      end
      if (v2_ff && !got95_ff && acc_sum > x95_ff) begin
         i95_ff <= idx2_ff;
      end
      if (v2_ff && !got99_ff && acc_sum > x99_ff) begin
         i99_ff <= idx2_ff;
      end
   end

   // result register
   always_comb begin
      rsp_item_in.total_count = total_ff;
      rsp_item_in.success_count = ok_ff;
      rsp_item_in.fail_count = bad_ff;
      rsp_item_in.time_sum = sum_ff;
      rsp_item_in.min_time = min_ff;
      rsp_item_in.max_time = max_ff;
      if (total_ff == '0) begin
         rsp_item_in.p95_time = '0;
         rsp_item_in.p99_time = '0;
      end else begin
         rsp_item_in.p95_time = got95_ff
            ? TIME_W'((TIME_W'(i95_ff) + TIME_W'(1)) * TIME_W'(BKT_US)) : max_ff;
         rsp_item_in.p99_time = got99_ff
            ? TIME_W'((TIME_W'(i99_ff) + TIME_W'(1)) * TIME_W'(BKT_US)) : max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   assign status.addr_end = (addr_ff == LAST_IDX);
   assign status.walk_done = got99_ff || ((addr_ff == LAST_IDX) && !v1_ff && !v2_ff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/lhs_controller.sv
// Controller: sequences record, query and clear items over the datapath.
module lhs_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_kind,
   input  lhs_pkg::status_type status,
   output logic                req_stall,
   output lhs_pkg::cmd_type    cmd
);
   import lhs_pkg::*;

   state_type state_ff, state_in;
   logic accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.addr_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  REQ_RECORD: state_in = ST_REC_MUL;
                  REQ_QUERY: state_in = ST_Q_INIT;
                  REQ_CLEAR: state_in = ST_CLEAR;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_REC_MUL: state_in = ST_REC_READ;
         ST_REC_READ: state_in = ST_REC_WRITE;
         ST_REC_WRITE: state_in = ST_IDLE;
         ST_Q_INIT: state_in = ST_Q_WALK;
         ST_Q_WALK: begin
            if (status.walk_done) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            cmd.rec_stats = accept && (req_kind == REQ_RECORD);
            cmd.clr_stats = accept && (req_kind == REQ_CLEAR);
            cmd.addr_rst = accept && (req_kind == REQ_CLEAR);
         end
         ST_REC_MUL: cmd.mul = 1'b1;
         ST_REC_READ: cmd.rd_rec = 1'b1;
         ST_REC_WRITE: cmd.wr_rec = 1'b1;
         ST_Q_INIT: begin
            cmd.q_init = 1'b1;
            cmd.addr_rst = 1'b1;
         end
         ST_Q_WALK: cmd.walk = 1'b1;
         ST_Q_DONE: cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/latency_histogram_stats.sv
// Latency histogram statistics monitor, top level.
//
// Input channel req_: one item per request. A record item adds a response time
// and a success flag, a query item asks for all statistics, a clear item zeroes
// them. Request type 3 is taken and ignored.
// Result channel rsp_: one item per query, with counts, time sum, min, max and
// the 95th and 99th percentile estimates.
// Steps: a record item goes through accept, index multiply, histogram read and
// histogram write. A query walks the histogram through the single read port of
// the bucket memory, and the walk stops early once the 99th percentile bucket is
// found. A clear item goes through the accept, then one memory entry is zeroed
// per cycle.
// Reset: runs the same clearing pass with req_stall high.
// A query result waits in the output register while rsp_stall is high; the
// block keeps taking record and clear items meanwhile, and a second query
// holds in its last step until the register is free.
module latency_histogram_stats #(
   parameter int BUCKETS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lhs_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lhs_pkg::rsp_item_type rsp_item
);
   import lhs_pkg::*;

   cmd_type cmd;
   status_type status;

   lhs_controller u_lhs_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.req_type),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   lhs_datapath #(
      .BUCKETS (BUCKETS)
   ) u_lhs_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/lhs_checker.sv
// Port checker for the latency histogram statistics block and its bind.
module lhs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input lhs_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lhs_pkg::rsp_item_type rsp_item
);
   import lhs_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("held item changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("item taken during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      req_take && (req_item.req_type == REQ_RECORD || req_item.req_type == REQ_QUERY
         || req_item.req_type == REQ_CLEAR) |=> req_stall)
      else $error("new item taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !$rose(rsp_valid))
      else $error("result right after item taken");

endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (.*);

### bench/latency_histogram_stats_tb.sv
// Testbench of the latency histogram statistics monitor with its own statistics model.
module latency_histogram_stats_tb;
   import lhs_pkg::*;

   localparam int BUCKETS = 1024;
   localparam int RANDOM_ITEMS = 950;
   localparam int MIN_QUERIES = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [BKT_W-1:0] BIN_MAX = '1;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_item_type req_item;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   logic [BKT_W-1:0] hist_bins [0:BUCKETS];
   logic [CNT_W-1:0] cnt_total;
   logic [CNT_W-1:0] cnt_ok;
   logic [CNT_W-1:0] cnt_bad;
   logic [SUM_W-1:0] sum_time;
   logic [TIME_W-1:0] min_seen;
   logic [TIME_W-1:0] max_seen;

   rsp_item_type stats_expected [$];
   rsp_item_type stats_want;
   int mismatch_count = 0;
   int cycle_count = 0;

   int burst_left = 0;
   int gap_max = 0;
   int stall_pct = 0;
   int stall_run_left = 0;
   logic stall_next = 1'b0;
   int rsp_hold_left = 0;

   latency_histogram_stats #(
      .BUCKETS(BUCKETS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void stats_clear();
      for (int i = 0; i <= BUCKETS; i++) hist_bins[i] = '0;
      cnt_total = '0;
      cnt_ok = '0;
      cnt_bad = '0;
      sum_time = '0;
      min_seen = '0;
      max_seen = '0;
   endfunction

   function automatic void stats_record(logic [TIME_W-1:0] t, logic ok);
      int unsigned bin;
      if (cnt_total != CNT_MAX) cnt_total++;
      if (ok) begin
         if (cnt_ok != CNT_MAX) cnt_ok++;
      end else begin
         if (cnt_bad != CNT_MAX) cnt_bad++;
      end
      if (sum_time > ~SUM_W'(t)) sum_time = '1;
      else sum_time += SUM_W'(t);
      if (min_seen == '0 || t < min_seen) min_seen = t;
      if (t > max_seen) max_seen = t;
      bin = t / BKT_US;
      if (bin >= BUCKETS) bin = BUCKETS;
      if (hist_bins[bin] != BIN_MAX) hist_bins[bin]++;
   endfunction

   function automatic rsp_item_type stats_report();
      rsp_item_type r;
      logic [63:0] t95;
      logic [63:0] t99;
      logic [63:0] run;
      logic got95;
      logic got99;
      r.total_count = cnt_total;
      r.success_count = cnt_ok;
      r.fail_count = cnt_bad;
      r.time_sum = sum_time;
      r.min_time = min_seen;
      r.max_time = max_seen;
      r.p95_time = '0;
      r.p99_time = '0;
      if (cnt_total != '0) begin
         t95 = (64'(cnt_total) * 64'd95) / 64'd100;
         t99 = (64'(cnt_total) * 64'd99) / 64'd100;
         run = '0;
         got95 = 1'b0;
         got99 = 1'b0;
         for (int i = 0; i < BUCKETS && !got99; i++) begin
            run += 64'(hist_bins[i]);
            if (!got95 && run >= t95) begin
               r.p95_time = TIME_W'((i + 1) * BKT_US);
               got95 = 1'b1;
            end
            if (!got99 && run >= t99) begin
               r.p99_time = TIME_W'((i + 1) * BKT_US);
               got99 = 1'b1;
            end
         end
         if (!got95) r.p95_time = max_seen;
         if (!got99) r.p99_time = max_seen;
      end
      return r;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [TIME_W-1:0] t, input logic ok);
      req_item_type item;
      int gap;
      item.req_type = kind;
      item.latency_us = t;
      item.ok_flag = ok;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (req_stall);
      case (kind)
         REQ_RECORD: stats_record(t, ok);
         REQ_QUERY: stats_expected.push_back(stats_report());
         REQ_CLEAR: stats_clear();
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (stats_expected.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_expected.size() == 0) begin
            $error("result item with no query waiting");
            mismatch_count++;
         end else begin
            stats_want = stats_expected.pop_front();
            check_field("total_count", 64'(stats_want.total_count), 64'(rsp_item.total_count));
            check_field("success_count", 64'(stats_want.success_count),
                        64'(rsp_item.success_count));
            check_field("fail_count", 64'(stats_want.fail_count), 64'(rsp_item.fail_count));
            check_field("time_sum", stats_want.time_sum, rsp_item.time_sum);
            check_field("min_time", 64'(stats_want.min_time), 64'(rsp_item.min_time));
            check_field("max_time", 64'(stats_want.max_time), 64'(rsp_item.max_time));
            check_field("p95_time", 64'(stats_want.p95_time), 64'(rsp_item.p95_time));
            check_field("p99_time", 64'(stats_want.p99_time), 64'(rsp_item.p99_time));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run_left == 0) begin
            stall_next = ($urandom_range(0, 99) < stall_pct);
            stall_run_left = $urandom_range(1, 8);
         end
         stall_run_left--;
         rsp_stall <= stall_next;
      end
   end

   function automatic logic [TIME_W-1:0] draw_time(int center, int spread, int tail_pct);
      int r;
      int bin;
      r = $urandom_range(0, 99);
      if (r < tail_pct) begin
         if ($urandom_range(0, 1)) return $urandom;
         return $urandom_range(BUCKETS * BKT_US, 5000000);
      end
      if (r < tail_pct + 4) return '0;
      bin = center + $urandom_range(0, spread);
      if (bin > BUCKETS - 1) bin = BUCKETS - 1;
      return TIME_W'(bin * BKT_US + $urandom_range(0, BKT_US - 1));
   endfunction

   task automatic test_directed_edges();
      stall_pct = 30;
      gap_max = 3;
      send_item(REQ_QUERY, '0, 1'b0);
      send_item(REQ_RECORD, '0, 1'b1);
      send_item(REQ_QUERY, '1, 1'b1);
      send_item(REQ_RECORD, 32'd5, 1'b0);
      send_item(REQ_UNUSED, 32'h5555_AAAA, 1'b1);
      send_item(REQ_RECORD, '1, 1'b1);
      send_item(REQ_RECORD, 32'd999, 1'b0);
      send_item(REQ_RECORD, 32'd1000, 1'b1);
      send_item(REQ_RECORD, TIME_W'(BUCKETS * BKT_US - 1), 1'b1);
      send_item(REQ_RECORD, TIME_W'(BUCKETS * BKT_US), 1'b0);
      send_item(REQ_QUERY, 32'hAAAA_5555, 1'b0);
      send_item(REQ_CLEAR, 32'hFFFF_0000, 1'b1);
      send_item(REQ_QUERY, '0, 1'b1);
   endtask

   task automatic test_percentile_fallback();
      send_item(REQ_RECORD, 32'd1500, 1'b1);
      send_item(REQ_RECORD, 32'h8000_0000, 1'b0);
      send_item(REQ_RECORD, 32'd3000000, 1'b1);
      send_item(REQ_RECORD, 32'h0000_FFFF, 1'b1);
      send_item(REQ_RECORD, 32'h7FFF_FFFF, 1'b0);
      send_item(REQ_QUERY, '0, 1'b0);
      send_item(REQ_CLEAR, '0, 1'b0);
   endtask

   task automatic test_output_backpressure();
      drain();
      stall_pct = 0;
      gap_max = 0;
      rsp_hold_left = 4000;
      repeat (3) begin
         send_item(REQ_QUERY, $urandom, 1'b1);
         repeat (30) send_item(REQ_RECORD, draw_time(2, 10, 5), $urandom_range(0, 1));
      end
      drain();
   endtask

   task automatic test_random_traffic();
      int sent;
      int queries;
      int phase_len;
      int center;
      int spread;
      int tail_pct;
      sent = 0;
      queries = 0;
      while (sent < RANDOM_ITEMS || queries < MIN_QUERIES) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
         endcase
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 10;
         endcase
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 3;
            2: spread = 50;
            default: spread = BUCKETS;
         endcase
         case ($urandom_range(0, 3))
            0: tail_pct = 0;
            1: tail_pct = 2;
            2: tail_pct = 10;
            default: tail_pct = 60;
         endcase
         center = $urandom_range(0, BUCKETS - 1);
         if ($urandom_range(0, 5) == 0) begin
            send_item(REQ_CLEAR, $urandom, 1'($urandom_range(0, 1)));
            sent++;
         end
         phase_len = $urandom_range(0, 40);
         repeat (phase_len) begin
            if ($urandom_range(0, 29) == 0)
               send_item(REQ_UNUSED, $urandom, 1'($urandom_range(0, 1)));
            send_item(REQ_RECORD, draw_time(center, spread, tail_pct),
                      1'($urandom_range(0, 1)));
            sent++;
         end
         send_item(REQ_QUERY, $urandom, 1'($urandom_range(0, 1)));
         sent++;
         queries++;
         if ($urandom_range(0, 7) == 0) begin
            send_item(REQ_QUERY, $urandom, 1'($urandom_range(0, 1)));
            sent++;
            queries++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      stats_clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_percentile_fallback();
      test_output_backpressure();
      test_random_traffic();
      drain();
      stall_pct = 0;
      repeat (BUCKETS + 64) @(posedge clock);
      if (stats_expected.size() != 0) begin
         $error("%0d query results never arrived", stats_expected.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
